[src/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// Credit flow controller package
// Shared item and result types, operation and result codes, register
// indexes, reset values and the controller-to-datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  // Default number of entries in the ack backlog.
  localparam int BACKLOG_DEPTH_DEF = 16;

  // Upper bound on backlog entries drained by a single receive.
  localparam int MAX_DRAIN = 17;
  localparam int DRAIN_W   = $clog2(MAX_DRAIN + 1);

  // Operation codes of an input request.
  localparam logic [1:0] OP_RECEIVE    = 2'd0;
  localparam logic [1:0] OP_SEND       = 2'd1;
  localparam logic [1:0] OP_CONNECT    = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_CREDIT_CAP = 2'd0;
  localparam logic [1:0] REG_PEER_GRANT = 2'd1;
  localparam logic [1:0] REG_CHUNK_LEN  = 2'd2;

  // Configuration reset values.
  localparam logic [9:0]  CREDIT_CAP_RST = 10'd15;
  localparam logic [9:0]  PEER_GRANT_RST = 10'd16;
  localparam logic [23:0] CHUNK_LEN_RST  = 24'd65536;

  // Saturation limits of the counters.
  localparam logic [9:0]  COUNT_MAX = 10'h3FF;
  localparam logic [15:0] REQ_MAX   = 16'hFFFF;

  // Result kinds.
  localparam logic [3:0] K_ACK        = 4'd0;
  localparam logic [3:0] K_WRITE_ONLY = 4'd1;
  localparam logic [3:0] K_DRAIN      = 4'd2;
  localparam logic [3:0] K_NOOP       = 4'd3;
  localparam logic [3:0] K_DELIVER    = 4'd4;
  localparam logic [3:0] K_RELEASE    = 4'd5;
  localparam logic [3:0] K_FREE       = 4'd6;
  localparam logic [3:0] K_FULL       = 4'd7;
  localparam logic [3:0] K_OVERFLOW   = 4'd8;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  msg_credits;
    logic        is_request;
    logic [15:0] tag;
    logic [23:0] xfer_size;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] out_tag;
    logic [9:0]  credits_returned;
    logic [23:0] send_size;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       clear_conn;
    logic       set_broken;
    logic       rx_add;
    logic       mem_rd;
    logic       drain_step;
    logic       req_inc;
    logic       ret_bump;
    logic       ack_step;
    logic       queue_push;
    logic       out_dec;
    logic       emit;
    logic [3:0] emit_kind;
    logic       emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] new_op;
    logic       is_request;
    logic       out_free;
    logic       overflow;
    logic       drain_after_add;
    logic       noop_after_add;
    logic       drain_ok;
    logic       drain_more_after;
    logic       noop_if_zero;
    logic       noop_if_cur;
    logic       credit_nz;
    logic       backlog_full;
    logic       broken;
    logic       outst_zero;
    logic       outst_dec_zero;
  } sts_t;

endpackage

`default_nettype wire

[src/cfp_datapath.sv]
// ----------------------------------------------------------------------------
// Credit flow controller datapath
// Holds the configuration, the connection counters, the ack backlog memory
// and the result register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_datapath #(
  parameter int BACKLOG_DEPTH = cfp_pkg::BACKLOG_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [23:0]      cfg_data,
  input  wire cfp_pkg::item_t   item,
  input  wire cfp_pkg::cmd_t    cmd,
  output cfp_pkg::sts_t         sts,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output cfp_pkg::result_t      result
);

  localparam int PW = $clog2(BACKLOG_DEPTH);
  localparam int FW = $clog2(BACKLOG_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam logic [PW-1:0] HEAD_LAST = PW'(BACKLOG_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(BACKLOG_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(BACKLOG_DEPTH);

  logic [9:0]          credit_cap;
  logic [9:0]          peer_grant;
  logic [23:0]         chunk_len;
  cfp_pkg::item_t      cur;
  logic [9:0]          credit_count;
  logic [9:0]          returning_count;
  logic [15:0]         outstanding;
  logic                conn_broken;
  logic [PW-1:0]       backlog_head;
  logic [FW-1:0]       backlog_fill;
  logic [15:0]         rd_tag;
  logic [15:0]         backlog_mem [BACKLOG_DEPTH];

  logic [10:0]         credit_sum;
  logic                overflow;
  logic [9:0]          credit_added;
  logic [9:0]          noop_thresh;
  logic [9:0]          ret_inc;
  logic                noop_if_cur;
  logic                noop_if_zero;
  logic                fill_nz;
  logic                drain_after_add;
  logic [SW-1:0]       wr_sum;
  logic [PW-1:0]       wr_addr;
  logic [PW-1:0]       head_next;
  logic [23:0]         size_min;
  logic                out_free;
  cfp_pkg::result_t    new_res;

  always_comb begin
    credit_sum      = {1'b0, credit_count} + {1'b0, cur.msg_credits};
    overflow        = credit_sum > {1'b0, credit_cap};
    credit_added    = overflow ? credit_cap : credit_sum[9:0];
    noop_thresh     = {1'b0, peer_grant[9:1]};
    ret_inc         = (returning_count == cfp_pkg::COUNT_MAX) ? cfp_pkg::COUNT_MAX
                                                              : returning_count + 10'd1;
    noop_if_cur     = ret_inc >= noop_thresh;
    noop_if_zero    = 10'd1 >= noop_thresh;
    fill_nz         = backlog_fill != '0;
    drain_after_add = (credit_added != 10'd0) && fill_nz;
    wr_sum          = SW'(backlog_head) + SW'(backlog_fill);
    wr_addr         = (wr_sum >= DEPTH_S) ? PW'(wr_sum - DEPTH_S) : PW'(wr_sum);
    head_next       = (backlog_head == HEAD_LAST) ? '0 : backlog_head + PW'(1);
    size_min        = (cur.xfer_size < chunk_len) ? cur.xfer_size : chunk_len;
    out_free        = !result_valid || !result_stall;
  end

  always_comb begin
    sts.new_op           = item.op;
    sts.is_request       = cur.is_request;
    sts.out_free         = out_free;
    sts.overflow         = overflow;
    sts.drain_after_add  = drain_after_add;
    sts.noop_after_add   = drain_after_add ? noop_if_zero : noop_if_cur;
    sts.drain_ok         = (credit_count != 10'd0) && fill_nz;
    sts.drain_more_after = (credit_count > 10'd1) && (backlog_fill > FW'(1));
    sts.noop_if_zero     = noop_if_zero;
    sts.noop_if_cur      = noop_if_cur;
    sts.credit_nz        = credit_count != 10'd0;
    sts.backlog_full     = backlog_fill == FILL_FULL;
    sts.broken           = conn_broken;
    sts.outst_zero       = outstanding == 16'd0;
    sts.outst_dec_zero   = outstanding <= 16'd1;
  end

  // Field contents depend on the result kind; unused fields are zero.
  always_comb begin
    new_res.kind = cmd.emit_kind;
    new_res.last = cmd.emit_last;
    unique case (cmd.emit_kind)
      cfp_pkg::K_ACK, cfp_pkg::K_WRITE_ONLY, cfp_pkg::K_FULL: begin
        new_res.out_tag          = cur.tag;
        new_res.credits_returned = (cmd.emit_kind == cfp_pkg::K_ACK) ? returning_count
                                                                     : 10'd0;
        new_res.send_size        = size_min;
      end
      cfp_pkg::K_RELEASE: begin
        new_res.out_tag          = cur.tag;
        new_res.credits_returned = 10'd0;
        new_res.send_size        = 24'd0;
      end
      cfp_pkg::K_DRAIN: begin
        new_res.out_tag          = rd_tag;
        new_res.credits_returned = returning_count;
        new_res.send_size        = 24'd0;
      end
      cfp_pkg::K_NOOP: begin
        new_res.out_tag          = 16'd0;
        new_res.credits_returned = ret_inc;
        new_res.send_size        = 24'd0;
      end
      default: begin
        new_res.out_tag          = 16'd0;
        new_res.credits_returned = 10'd0;
        new_res.send_size        = 24'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_cap      <= cfp_pkg::CREDIT_CAP_RST;
      peer_grant      <= cfp_pkg::PEER_GRANT_RST;
      chunk_len       <= cfp_pkg::CHUNK_LEN_RST;
      credit_count    <= 10'd0;
      returning_count <= 10'd0;
      outstanding     <= 16'd0;
      conn_broken     <= 1'b0;
      backlog_head    <= '0;
      backlog_fill    <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cfp_pkg::REG_CREDIT_CAP: credit_cap <= cfg_data[9:0];
          cfp_pkg::REG_PEER_GRANT: peer_grant <= cfg_data[9:0];
          cfp_pkg::REG_CHUNK_LEN:  chunk_len  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_conn) begin
        credit_count    <= peer_grant;
        returning_count <= 10'd0;
        outstanding     <= 16'd0;
        conn_broken     <= 1'b0;
        backlog_head    <= '0;
        backlog_fill    <= '0;
      end
      if (cmd.set_broken) begin
        conn_broken <= 1'b1;
      end
      if (cmd.rx_add) begin
        credit_count <= credit_added;
      end
      if (cmd.drain_step) begin
        returning_count <= 10'd0;
        backlog_head    <= head_next;
        backlog_fill    <= backlog_fill - FW'(1);
        credit_count    <= credit_count - 10'd1;
      end
      if (cmd.req_inc && (outstanding != cfp_pkg::REQ_MAX)) begin
        outstanding <= outstanding + 16'd1;
      end
      if (cmd.ret_bump) begin
        returning_count <= noop_if_cur ? 10'd0 : ret_inc;
      end
      if (cmd.ack_step) begin
        returning_count <= 10'd0;
        credit_count    <= credit_count - 10'd1;
      end
      if (cmd.queue_push) begin
        backlog_fill <= backlog_fill + FW'(1);
      end
      if (cmd.out_dec && (outstanding != 16'd0)) begin
        outstanding <= outstanding - 16'd1;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
    if (cmd.emit) begin
      result <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.queue_push) begin
      backlog_mem[wr_addr] <= cur.tag;
    end
    if (cmd.mem_rd) begin
      rd_tag <= backlog_mem[backlog_head];
    end
  end

endmodule

`default_nettype wire

[src/cfp_ctrl.sv]
// ----------------------------------------------------------------------------
// Credit flow controller sequencer
// State machine that walks one request through its steps and tells the
// datapath what to update and which result to produce.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  output cfp_pkg::cmd_t      cmd,
  input  wire cfp_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_RX_ADD     = 4'd1;
  localparam logic [3:0] S_DRAIN_RD   = 4'd2;
  localparam logic [3:0] S_DRAIN_EMIT = 4'd3;
  localparam logic [3:0] S_RX_REQ     = 4'd4;
  localparam logic [3:0] S_RX_NOOP    = 4'd5;
  localparam logic [3:0] S_TX         = 4'd6;
  localparam logic [3:0] S_TX_FREE    = 4'd7;
  localparam logic [3:0] S_DISC       = 4'd8;

  localparam logic [cfp_pkg::DRAIN_W-1:0] DRAIN_MAX  = cfp_pkg::DRAIN_W'(cfp_pkg::MAX_DRAIN);
  localparam logic [cfp_pkg::DRAIN_W-1:0] DRAIN_LAST =
    cfp_pkg::DRAIN_W'(cfp_pkg::MAX_DRAIN - 1);

  logic [3:0]                     state;
  logic [3:0]                     state_next;
  logic [cfp_pkg::DRAIN_W-1:0]    drained;
  logic [cfp_pkg::DRAIN_W-1:0]    drained_next;

  assign item_stall = state != S_IDLE;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    drained_next = drained;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch    = 1'b1;
          drained_next = '0;
          unique case (sts.new_op)
            cfp_pkg::OP_RECEIVE:    state_next = S_RX_ADD;
            cfp_pkg::OP_SEND:       state_next = S_TX;
            cfp_pkg::OP_CONNECT:    cmd.clear_conn = 1'b1;
            cfp_pkg::OP_DISCONNECT: state_next = S_DISC;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_RX_ADD: begin
        if (!sts.overflow || sts.out_free) begin
          cmd.rx_add    = 1'b1;
          cmd.emit      = sts.overflow;
          cmd.emit_kind = cfp_pkg::K_OVERFLOW;
          cmd.emit_last = !(sts.drain_after_add || sts.is_request || sts.noop_after_add);
          state_next    = S_DRAIN_RD;
        end
      end
      S_DRAIN_RD: begin
        if (sts.drain_ok && (drained < DRAIN_MAX)) begin
          cmd.mem_rd = 1'b1;
          state_next = S_DRAIN_EMIT;
        end else begin
          state_next = S_RX_REQ;
        end
      end
      S_DRAIN_EMIT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = cfp_pkg::K_DRAIN;
          cmd.emit_last  = !((sts.drain_more_after && (drained < DRAIN_LAST)) ||
                             sts.is_request || sts.noop_if_zero);
          cmd.drain_step = 1'b1;
          drained_next   = drained + cfp_pkg::DRAIN_W'(1);
          state_next     = S_DRAIN_RD;
        end
      end
      S_RX_REQ: begin
        if (!sts.is_request) begin
          state_next = S_RX_NOOP;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cfp_pkg::K_DELIVER;
          cmd.emit_last = !sts.noop_if_cur;
          cmd.req_inc   = 1'b1;
          state_next    = S_RX_NOOP;
        end
      end
      S_RX_NOOP: begin
        if (!sts.noop_if_cur) begin
          cmd.ret_bump = 1'b1;
          state_next   = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cfp_pkg::K_NOOP;
          cmd.emit_last = 1'b1;
          cmd.ret_bump  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TX: begin
        if (sts.out_free) begin
          cmd.out_dec = 1'b1;
          cmd.emit    = 1'b1;
          state_next  = S_IDLE;
          if (sts.broken) begin
            cmd.emit_kind = cfp_pkg::K_RELEASE;
            cmd.emit_last = !sts.outst_dec_zero;
            if (sts.outst_dec_zero) begin
              state_next = S_TX_FREE;
            end
          end else if (sts.credit_nz) begin
            cmd.emit_kind = cfp_pkg::K_ACK;
            cmd.emit_last = 1'b1;
            cmd.ack_step  = 1'b1;
          end else if (!sts.backlog_full) begin
            cmd.emit_kind  = cfp_pkg::K_WRITE_ONLY;
            cmd.emit_last  = 1'b1;
            cmd.queue_push = 1'b1;
          end else begin
            cmd.emit_kind = cfp_pkg::K_FULL;
            cmd.emit_last = 1'b1;
          end
        end
      end
      S_TX_FREE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cfp_pkg::K_FREE;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DISC: begin
        if (!sts.outst_zero) begin
          cmd.set_broken = 1'b1;
          state_next     = S_IDLE;
        end else if (sts.out_free) begin
          cmd.set_broken = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = cfp_pkg::K_FREE;
          cmd.emit_last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      drained <= '0;
    end else begin
      state   <= state_next;
      drained <= drained_next;
    end
  end

endmodule

`default_nettype wire

[src/credit_flow_controller_core.sv]
// ----------------------------------------------------------------------------
// Credit flow controller core: send-credit engine of one connection.
// A connect takes effect on acceptance; a send also emits a free when a chunk
// release frees the connection; a receive drains backlog acks one by one; each
// result waits for the single output register. Synchronous reset clears
// counters, backlog pointers and control; backlog memory contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_flow_controller_core #(
  parameter int BACKLOG_DEPTH = cfp_pkg::BACKLOG_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // Configuration write port.
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [23:0]     cfg_data,
  // Request channel.
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire cfp_pkg::item_t  item,
  // Result channel.
  output logic                 result_valid,
  input  wire logic            result_stall,
  output cfp_pkg::result_t     result
);

  // The sequencer owns the order of steps: add returned credits, drain the
  // backlog one entry at a time, deliver a request, then decide on a noop.
  // Every step that produces a result first waits until the output register
  // can take it, so a stalled consumer simply freezes the sequence.
  cfp_pkg::cmd_t cmd;
  cfp_pkg::sts_t sts;

  cfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath keeps the credit, returning and outstanding-request counters,
  // the backlog memory with its head pointer and fill count, and the result
  // register. The last flag of each result is worked out ahead from the
  // status lookahead, so results leave as soon as they are formed.
  cfp_datapath #(
    .BACKLOG_DEPTH (BACKLOG_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A result is only formed when the output register has room for it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result formed while the output register is occupied");

  // A backlog read is only issued for a filled entry with a credit to spend.
  a_drain_read_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> sts.drain_ok)
    else $error("backlog read without a queued entry or a credit");

  // An ack is queued only on a live connection that is out of credits and
  // whose backlog still has room.
  a_queue_push_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.queue_push |-> (!sts.backlog_full && !sts.credit_nz && !sts.broken))
    else $error("ack queued when it should have been sent or refused");

  // A new request is never taken while a result of the previous one is formed.
  a_accept_not_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |-> !cmd.emit)
    else $error("request accepted while a result is being formed");

endmodule

`default_nettype wire
